// ===== design/h2r_pkg.sv =====
// Shared constants and types for the HSL to RGB converter.
`default_nettype none

package h2r_pkg;

    localparam int HUE_W = 9;
    localparam int PCT_W = 7;
    localparam int VAL_W = 14;   // v and m over 10000, at most 10000
    localparam int NUM_W = 20;   // channel numerators over 600000
    localparam int SCL_W = 24;   // numerator times 17, at most 10200000
    localparam int CHN_W = 8;

    localparam logic [HUE_W-1:0] HUE_MAX = 9'd359;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;

    // floor(h / 60) = (h * 1093) >> 16 for every h up to 359
    localparam logic [10:0] SEXT_RECIP = 11'd1093;
    localparam int SEXT_SHIFT = 16;

    // floor(y / 40000) = (y * 27487791) >> 40 for every y up to 10200000
    localparam int RECIP_W = 25;
    localparam logic [RECIP_W-1:0] CHN_RECIP = 25'd27487791;
    localparam int CHN_SHIFT = 40;
    localparam int PROD_W = SCL_W + RECIP_W;

    typedef enum logic [2:0] {
        SEXT_RED_YEL = 3'd0,
        SEXT_YEL_GRN = 3'd1,
        SEXT_GRN_CYN = 3'd2,
        SEXT_CYN_BLU = 3'd3,
        SEXT_BLU_MAG = 3'd4,
        SEXT_MAG_RED = 3'd5
    } t_sextant;

endpackage

`default_nettype wire

// ===== design/h2r_scale.sv =====
// Final stage: scale the three channel numerators to 8-bit values.
`default_nettype none

module h2r_scale
    import h2r_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [SCL_W-1:0] i_red_num,
    input  wire logic [SCL_W-1:0] i_green_num,
    input  wire logic [SCL_W-1:0] i_blue_num,
    output logic                  o_valid,
    output logic [CHN_W-1:0]      o_red,
    output logic [CHN_W-1:0]      o_green,
    output logic [CHN_W-1:0]      o_blue
);

    logic [PROD_W-1:0] w_red_prod;
    logic [PROD_W-1:0] w_green_prod;
    logic [PROD_W-1:0] w_blue_prod;
    logic              r_valid;
    logic [CHN_W-1:0]  r_red;
    logic [CHN_W-1:0]  r_green;
    logic [CHN_W-1:0]  r_blue;

    // divide by 40000 through the reciprocal; exact over the whole range
    assign w_red_prod   = PROD_W'(i_red_num)   * PROD_W'(CHN_RECIP);
    assign w_green_prod = PROD_W'(i_green_num) * PROD_W'(CHN_RECIP);
    assign w_blue_prod  = PROD_W'(i_blue_num)  * PROD_W'(CHN_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= w_red_prod[CHN_SHIFT +: CHN_W];
        r_green <= w_green_prod[CHN_SHIFT +: CHN_W];
        r_blue  <= w_blue_prod[CHN_SHIFT +: CHN_W];
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

// ===== design/hsl_to_rgb_converter.sv =====
// Top level: pipelined HSL to RGB color converter.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------
//  request   i_hue, i_saturation, i_lightness        start high, busy low
//  result    o_red_out, o_green_out, o_blue_out      o_strobe for one cycle
//
// One request enters every clock cycle; busy never rises. The result of a
// request shows on the result ports once it has passed the four register
// stages: clamp and v/m, fraction and span product, mid values and
// channel select, reciprocal scaling. Reset (synchronous, active low)
// clears only the stage valid bits. The receiver cannot stall, so the
// pipeline always advances.
`default_nettype none

module hsl_to_rgb_converter
    import h2r_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [HUE_W-1:0] i_hue,
    input  wire logic [PCT_W-1:0] i_saturation,
    input  wire logic [PCT_W-1:0] i_lightness,
    output logic                  o_strobe,
    output logic [CHN_W-1:0]      o_red_out,
    output logic [CHN_W-1:0]      o_green_out,
    output logic [CHN_W-1:0]      o_blue_out
);

    // ---------------- stage 1: clamp, v, m and sextant ----------------
    logic [HUE_W-1:0] w_hue;
    logic [PCT_W-1:0] w_sat;
    logic [PCT_W-1:0] w_lit;
    logic [14:0]      w_v_low;
    logic [14:0]      w_v_high;
    logic [14:0]      w_v;
    logic [14:0]      w_m;
    logic [19:0]      w_hue_quot;

    logic             r1_valid;
    logic [VAL_W-1:0] r1_v;
    logic [VAL_W-1:0] r1_m;
    logic [HUE_W-1:0] r1_hue;
    logic [2:0]       r1_sext;

    // saturate out-of-range requests
    assign w_hue = (i_hue > HUE_MAX) ? HUE_MAX : i_hue;
    assign w_sat = (i_saturation > PCT_MAX) ? PCT_MAX : i_saturation;
    assign w_lit = (i_lightness > PCT_MAX) ? PCT_MAX : i_lightness;

    // v and m over 10000; lightness zero gives v = m = 0, so black falls out
    assign w_v_low  = 15'(w_lit) * (15'd100 + 15'(w_sat));
    assign w_v_high = 15'(w_lit) * 15'd100 + 15'(w_sat) * (15'd100 - 15'(w_lit));
    assign w_v      = (w_lit <= PCT_HALF) ? w_v_low : w_v_high;
    assign w_m      = 15'(w_lit) * 15'd200 - w_v;

    // sextant = hue / 60 by reciprocal multiply
    assign w_hue_quot = 20'(w_hue) * 20'(SEXT_RECIP);

    always_ff @(posedge i_clk) begin
        r1_v    <= w_v[VAL_W-1:0];
        r1_m    <= w_m[VAL_W-1:0];
        r1_hue  <= w_hue;
        r1_sext <= w_hue_quot[SEXT_SHIFT +: 3];
    end

    // ---------------- stage 2: fraction, span product, scale by 60 -----
    logic [HUE_W-1:0] w_frac_full;
    logic [5:0]       w_frac;
    logic [VAL_W-1:0] w_span;

    logic             r2_valid;
    logic [NUM_W-1:0] r2_span_frac;
    logic [NUM_W-1:0] r2_v60;
    logic [NUM_W-1:0] r2_m60;
    logic [2:0]       r2_sext;

    assign w_frac_full = r1_hue - HUE_W'(r1_sext) * 9'd60;
    assign w_frac      = w_frac_full[5:0];
    assign w_span      = r1_v - r1_m;

    always_ff @(posedge i_clk) begin
        r2_span_frac <= NUM_W'(w_span) * NUM_W'(w_frac);
        r2_v60       <= NUM_W'(r1_v) * 20'd60;
        r2_m60       <= NUM_W'(r1_m) * 20'd60;
        r2_sext      <= r1_sext;
    end

    // ---------------- stage 3: mid values, channel select, times 17 ----
    logic [NUM_W-1:0] w_mid_up;
    logic [NUM_W-1:0] w_mid_down;
    logic [NUM_W-1:0] w_red;
    logic [NUM_W-1:0] w_green;
    logic [NUM_W-1:0] w_blue;

    logic             r3_valid;
    logic [SCL_W-1:0] r3_red;
    logic [SCL_W-1:0] r3_green;
    logic [SCL_W-1:0] r3_blue;

    assign w_mid_up   = r2_m60 + r2_span_frac;
    assign w_mid_down = r2_v60 - r2_span_frac;

    always_comb begin
        case (t_sextant'(r2_sext))
            SEXT_RED_YEL: begin
                w_red = r2_v60;     w_green = w_mid_up;   w_blue = r2_m60;
            end
            SEXT_YEL_GRN: begin
                w_red = w_mid_down; w_green = r2_v60;     w_blue = r2_m60;
            end
            SEXT_GRN_CYN: begin
                w_red = r2_m60;     w_green = r2_v60;     w_blue = w_mid_up;
            end
            SEXT_CYN_BLU: begin
                w_red = r2_m60;     w_green = w_mid_down; w_blue = r2_v60;
            end
            SEXT_BLU_MAG: begin
                w_red = w_mid_up;   w_green = r2_m60;     w_blue = r2_v60;
            end
            default: begin
                w_red = r2_v60;     w_green = r2_m60;     w_blue = w_mid_down;
            end
        endcase
    end

    // channel = floor(num * 255 / 600000) = floor(num * 17 / 40000)
    always_ff @(posedge i_clk) begin
        r3_red   <= SCL_W'(w_red)   * 24'd17;
        r3_green <= SCL_W'(w_green) * 24'd17;
        r3_blue  <= SCL_W'(w_blue)  * 24'd17;
    end

    // valid bits advance with the data every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= start;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // ---------------- stage 4: divide by 40000 and register results ----
    h2r_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r3_valid),
        .i_red_num   (r3_red),
        .i_green_num (r3_green),
        .i_blue_num  (r3_blue),
        .o_valid     (o_strobe),
        .o_red       (o_red_out),
        .o_green     (o_green_out),
        .o_blue      (o_blue_out)
    );

    // the pipeline never holds off a request
    assign busy = 1'b0;

endmodule

`default_nettype wire

// ===== design/h2r_checker.sv =====
// Port-level checks for the HSL to RGB converter, bound to the top level.
`default_nettype none

module h2r_checker
    import h2r_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic [HUE_W-1:0] i_hue,
    input wire logic [PCT_W-1:0] i_saturation,
    input wire logic [PCT_W-1:0] i_lightness,
    input wire logic             o_strobe,
    input wire logic [CHN_W-1:0] o_red_out,
    input wire logic [CHN_W-1:0] o_green_out,
    input wire logic [CHN_W-1:0] o_blue_out
);

    // every accepted request gives one matching result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("request without matching result strobe");

    // no strobe without a matching earlier request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##4 !o_strobe)
        else $error("result strobe without request");

    // lightness zero is black whatever hue and saturation say
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_lightness == 7'd0) |->
        ##4 (o_red_out == 8'd0 && o_green_out == 8'd0 && o_blue_out == 8'd0))
        else $error("zero lightness did not give black");

    // saturation zero gives a gray: all channels equal
    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_saturation == 7'd0) |->
        ##4 (o_red_out == o_green_out && o_green_out == o_blue_out))
        else $error("zero saturation did not give gray");

endmodule

bind hsl_to_rgb_converter h2r_checker u_h2r_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_hue        (i_hue),
    .i_saturation (i_saturation),
    .i_lightness  (i_lightness),
    .o_strobe     (o_strobe),
    .o_red_out    (o_red_out),
    .o_green_out  (o_green_out),
    .o_blue_out   (o_blue_out)
);

`default_nettype wire

// ===== tb/hsl_rgb_checker.sv =====
// Checker for the HSL to RGB converter: predicts each color and compares the results.
`timescale 1ns / 100ps

module hsl_rgb_checker
    import h2r_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [PCT_W-1:0] i_saturation,
    input  logic [PCT_W-1:0] i_lightness,
    input  logic             i_strobe,
    input  logic [CHN_W-1:0] i_red_out,
    input  logic [CHN_W-1:0] i_green_out,
    input  logic [CHN_W-1:0] i_blue_out,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [CHN_W-1:0] red;
        logic [CHN_W-1:0] green;
        logic [CHN_W-1:0] blue;
    } t_rgb;

    t_rgb rgb_due[$];

    // Scale a numerator over 600000 to an 8-bit channel, truncating.
    function automatic logic [CHN_W-1:0] to_channel(longint unsigned num);
        longint unsigned scaled;
        scaled = (num * 255) / 600000;
        return scaled[CHN_W-1:0];
    endfunction

    function automatic t_rgb expected_rgb(logic [HUE_W-1:0] hue_in,
                                          logic [PCT_W-1:0] sat_in,
                                          logic [PCT_W-1:0] lit_in);
        longint unsigned h, s, l, v, m, span, frac, rise, fall, r, g, b;
        t_sextant sext;
        t_rgb rgb;
        h = (hue_in > HUE_MAX) ? HUE_MAX : hue_in;
        s = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
        l = (lit_in > PCT_MAX) ? PCT_MAX : lit_in;
        // v and m over 10000
        if (l <= PCT_HALF) begin
            v = l * (100 + s);
        end else begin
            v = 100 * l + s * (100 - l);
        end
        m = 200 * l - v;
        if (v == 0) begin
            rgb = '0;
            return rgb;
        end
        span = v - m;
        v = v * 60;
        m = m * 60;
        frac = h % 60;
        rise = m + span * frac;
        fall = v - span * frac;
        sext = t_sextant'(h / 60);
        case (sext)
            SEXT_RED_YEL: begin r = v;    g = rise; b = m;    end
            SEXT_YEL_GRN: begin r = fall; g = v;    b = m;    end
            SEXT_GRN_CYN: begin r = m;    g = v;    b = rise; end
            SEXT_CYN_BLU: begin r = m;    g = fall; b = v;    end
            SEXT_BLU_MAG: begin r = rise; g = m;    b = v;    end
            default:      begin r = v;    g = m;    b = fall; end
        endcase
        rgb.red   = to_channel(r);
        rgb.green = to_channel(g);
        rgb.blue  = to_channel(b);
        return rgb;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_rgb want;
        t_rgb got;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                rgb_due.push_back(expected_rgb(i_hue, i_saturation, i_lightness));
            end
            if (i_strobe) begin
                got = '{i_red_out, i_green_out, i_blue_out};
                if (rgb_due.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) begin
                        $display("%0t: color result with no request waiting: rgb %0d %0d %0d",
                                 $realtime, got.red, got.green, got.blue);
                    end
                end else begin
                    want = rgb_due.pop_front();
                    if (got != want) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("%0t: color mismatch: expected rgb %0d %0d %0d, got %0d %0d %0d",
                                     $realtime, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        end
                    end
                end
            end
            o_pending = rgb_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives color requests into the converter and gives the verdict.
`timescale 1ns / 100ps

module tb;
    import h2r_pkg::*;

    // Stimulus size: random requests after the directed ones, and how many of
    // them at the tail run back to back with no idle cycles.
    localparam int RANDOM_REQS = 1850;
    localparam int FLAT_OUT_TAIL = 200;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [HUE_W-1:0] i_hue = '0;
    logic [PCT_W-1:0] i_saturation = '0;
    logic [PCT_W-1:0] i_lightness = '0;
    logic             o_strobe;
    logic [CHN_W-1:0] o_red_out;
    logic [CHN_W-1:0] o_green_out;
    logic [CHN_W-1:0] o_blue_out;
    int               fail_count;
    int               pending;

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    hsl_to_rgb_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_strobe     (o_strobe),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out)
    );

    // The checker sits beside the converter and sees the same ports; it
    // predicts every accepted request and compares the strobed results.
    hsl_rgb_checker color_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .i_strobe     (o_strobe),
        .i_red_out    (o_red_out),
        .i_green_out  (o_green_out),
        .i_blue_out   (o_blue_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Present one color and hold it until the converter takes it. Start stays
    // high on return, so back-to-back requests never drop it in between.
    task automatic send_color(int unsigned hue, int unsigned sat, int unsigned lit);
        i_hue        <= hue[HUE_W-1:0];
        i_saturation <= sat[PCT_W-1:0];
        i_lightness  <= lit[PCT_W-1:0];
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Drop start for an idle burst of random length.
    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge i_clk);
    endtask

    // Mostly in-range values; about one in ten lands above the limit so
    // that the clamp and the upper bits of each field get exercised.
    function automatic int unsigned pick_hue();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(HUE_MAX + 1, (1 << HUE_W) - 1);
        end
        return $urandom_range(0, HUE_MAX);
    endfunction

    function automatic int unsigned pick_percent();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 2) begin
            return $urandom_range(PCT_MAX + 1, (1 << PCT_W) - 1);
        end
        // Weight the ends of the range and the lightness knee a little.
        if (roll == 2) begin
            return $urandom_range(0, 1) ? 0 : PCT_MAX;
        end
        if (roll == 3) begin
            return $urandom_range(PCT_HALF - 1, PCT_HALF + 1);
        end
        return $urandom_range(0, PCT_MAX);
    endfunction

    initial begin
        int unsigned idle_odds;
        int guard;
        bit done_ok;

        // Hold reset low, then release it.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every sextant edge at full saturation, mid lightness.
        send_color(0, 100, 50);
        send_color(59, 100, 50);
        send_color(60, 100, 50);
        send_color(119, 100, 50);
        send_color(120, 100, 50);
        send_color(179, 100, 50);
        send_color(180, 100, 50);
        send_color(239, 100, 50);
        send_color(240, 100, 50);
        send_color(299, 100, 50);
        send_color(300, 100, 50);
        send_color(359, 100, 50);
        // Hue above range, and every field at its all-ones value.
        send_color(360, 100, 50);
        send_color(511, 127, 127);
        // Saturation or lightness above range.
        send_color(45, 127, 50);
        send_color(45, 60, 127);
        // Zero lightness gives black, with and without saturation.
        send_color(30, 100, 0);
        send_color(30, 0, 0);
        // Gray, white, and both sides of the lightness knee.
        send_color(200, 0, 40);
        send_color(100, 100, 100);
        send_color(0, 0, 100);
        send_color(10, 75, 50);
        send_color(10, 75, 51);
        send_color(250, 1, 1);

        // Random part: idle odds change every hundred requests, including
        // stretches with none; the tail runs flat out.
        idle_odds = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_odds = 0;
                    1: idle_odds = 3;
                    default: idle_odds = 8;
                endcase
            end
            if (n < RANDOM_REQS - FLAT_OUT_TAIL && idle_odds != 0 &&
                $urandom_range(1, idle_odds) == 1) begin
                idle_burst();
            end
            send_color(pick_hue(), pick_percent(), pick_percent());
        end
        start <= 1'b0;

        // Drain: wait for every expected color, bounded, then let the
        // four-stage pipeline settle to catch extras.
        guard = 0;
        while (pending != 0 && guard < 200) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);

        done_ok = (fail_count == 0) && (pending == 0);
        if (done_ok) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run of a few hundred us.
    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
